>>> rtl/mbss_pkg.sv
// Shared types, constants and helper functions of the masked byte signature scanner.
package mbss_pkg;

  // Sizes of the signature and of the byte window.
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int WINDOW_DEPTH      = 16;
  localparam int COUNT_BITS        = 32;
  localparam int OFFSET_BITS       = 32;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int LEN_W             = 5;
  localparam int IDX_W             = 4;
  localparam int CMP_W             = (COUNT_BITS > OFFSET_BITS) ? COUNT_BITS : OFFSET_BITS;

  typedef logic [7:0]                          byte_t;
  typedef logic [MAX_PATTERN_BYTES-1:0][7:0]   byte_row_t;
  typedef logic [COUNT_BITS-1:0]               count_t;
  typedef logic [OFFSET_BITS-1:0]              offset_t;
  typedef logic [LEN_W-1:0]                    len_t;
  typedef logic [IDX_W-1:0]                    idx_t;

  localparam count_t  COUNT_MAX        = '1;
  localparam offset_t LATEST_UNLIMITED = '1;
  localparam byte_t   MASK_EXACT       = 8'hFF;
  localparam byte_t   MASK_WILDCARD    = 8'h00;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW   = 3'd0,
    REG_PATTERN_HIGH  = 3'd1,
    REG_MASK_LOW      = 3'd2,
    REG_MASK_HIGH     = 3'd3,
    REG_PATTERN_LEN   = 3'd4,
    REG_EARLIEST      = 3'd5,
    REG_LATEST        = 3'd6,
    REG_RETRY_CASE    = 3'd7
  } cfg_reg_e;

  // Outcome codes of a stream.
  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_MASKED   = 2'd1,
    KIND_CASELESS = 2'd2
  } match_kind_e;

  // Per-cell compare results handed to the top level.
  typedef struct packed {
    logic active;
    logic mask_ok;
    logic case_ok;
    logic letter;
  } cell_flags_t;

  // Upper-case ASCII letters are folded to lower case.
  function automatic byte_t fold_case(input byte_t b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'h20;
    end
    return b;
  endfunction

  function automatic logic is_letter(input byte_t b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

endpackage

>>> rtl/mbss_in_if.sv
// Input channel of the scanner: one data byte and its end-of-stream flag per item.
interface mbss_in_if import mbss_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

>>> rtl/mbss_out_if.sv
// Result channel of the scanner: outcome of one stream per item.
interface mbss_out_if import mbss_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        found;
  match_kind_e match_kind;

  modport source (output valid, found, match_kind, input ready);
  modport sink   (input valid, found, match_kind, output ready);
endinterface

>>> rtl/masked_byte_signature_scanner.sv
// Top level of the masked byte signature scanner: configuration, cell row, hit tracking and result register.
//
// The scanner takes one byte item in each cycle that input ready is high and holds the most recent bytes in a row of
// sixteen cells, each comparing the byte that enters it against its pattern byte under the mask and
// with letter case folded. On the item that carries final_byte the outcome of the stream is placed in
// the result register in the cycle after acceptance, and the stream state is cleared at once, so the
// first byte of the next stream may follow in the next cycle. Input ready falls only while a result
// waits in the result register and the sink does not take it in that cycle. The sustained rate of
// one byte per cycle is set by the combinational compare across the cell row and the window check on
// the byte count; there is no clearing pass after reset.
module masked_byte_signature_scanner import mbss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mbss_in_if.sink               in_i,
  mbss_out_if.source            out_o
);

  // Configuration registers.
  logic [63:0] pattern_low_q, pattern_high_q, mask_low_q, mask_high_q;
  len_t        plen_q;
  offset_t     earliest_q, latest_q;
  logic        retry_q;

  // Stream state and result register.
  count_t      count_q, count_d;
  logic        masked_hit_q, masked_hit_d;
  logic        caseless_hit_q, caseless_hit_d;
  logic        out_valid_q, out_valid_d;
  logic        found_q, found_d;
  match_kind_e kind_q, kind_d;

  logic        accept;
  len_t        len;
  byte_row_t   pattern_row, mask_row;
  byte_t       chain [WINDOW_DEPTH+1];
  cell_flags_t flags [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] mask_ok_v, case_ok_v, letter_v;
  logic        in_window, masked_now, caseless_now, all_letters;
  logic [CMP_W-1:0] pos_w, lm1_w, start_w, earliest_w, latest_w;

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q  <= '0;
      pattern_high_q <= '0;
      mask_low_q     <= '1;
      mask_high_q    <= '1;
      plen_q         <= len_t'(1);
      earliest_q     <= '0;
      latest_q       <= LATEST_UNLIMITED;
      retry_q        <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PATTERN_LOW:  pattern_low_q  <= cfg_data_i[63:0];
        REG_PATTERN_HIGH: pattern_high_q <= cfg_data_i[63:0];
        REG_MASK_LOW:     mask_low_q     <= cfg_data_i[63:0];
        REG_MASK_HIGH:    mask_high_q    <= cfg_data_i[63:0];
        REG_PATTERN_LEN:  plen_q         <= cfg_data_i[LEN_W-1:0];
        REG_EARLIEST:     earliest_q     <= cfg_data_i[OFFSET_BITS-1:0];
        REG_LATEST:       latest_q       <= cfg_data_i[OFFSET_BITS-1:0];
        REG_RETRY_CASE:   retry_q        <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // Length in use: zero counts as one, anything above the maximum is clipped.
  always_comb begin
    if (plen_q == '0) begin
      len = len_t'(1);
    end else if (plen_q > len_t'(MAX_PATTERN_BYTES)) begin
      len = len_t'(MAX_PATTERN_BYTES);
    end else begin
      len = plen_q;
    end
  end

  assign pattern_row = {pattern_high_q, pattern_low_q};
  assign mask_row    = {mask_high_q, mask_low_q};

  // Handshake: a result waiting in the register holds off new bytes unless it leaves now.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Row of cells; the newest byte enters cell zero.
  assign chain[0] = in_i.data_byte;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    mbss_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (accept),
      .data_i    (chain[k]),
      .idx_i     (idx_t'(k)),
      .len_i     (len),
      .pattern_i (pattern_row),
      .mask_i    (mask_row),
      .data_o    (chain[k+1]),
      .flags_o   (flags[k])
    );
    assign mask_ok_v[k] = flags[k].mask_ok || !flags[k].active;
    assign case_ok_v[k] = flags[k].case_ok || !flags[k].active;
    assign letter_v[k]  = flags[k].letter  || !flags[k].active;
  end

  // Start offset of the candidate that ends on this byte, and the window check.
  always_comb begin
    pos_w      = CMP_W'(count_q);
    lm1_w      = CMP_W'(len - len_t'(1));
    start_w    = pos_w - lm1_w;
    earliest_w = CMP_W'(earliest_q);
    latest_w   = CMP_W'(latest_q);
    in_window  = (pos_w >= lm1_w) && (start_w >= earliest_w) &&
                 ((latest_q == LATEST_UNLIMITED) || (start_w <= latest_w));
  end

  assign masked_now   = in_window && (&mask_ok_v);
  assign caseless_now = in_window && (&case_ok_v);
  assign all_letters  = &letter_v;

  // Stream state update and outcome of the final byte.
  always_comb begin
    count_d        = count_q;
    masked_hit_d   = masked_hit_q;
    caseless_hit_d = caseless_hit_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    found_d        = found_q;
    kind_d         = kind_q;
    if (accept) begin
      if (in_i.final_byte) begin
        count_d        = '0;
        masked_hit_d   = 1'b0;
        caseless_hit_d = 1'b0;
        out_valid_d    = 1'b1;
        if (masked_hit_q || masked_now) begin
          kind_d = KIND_MASKED;
        end else if ((caseless_hit_q || caseless_now) && retry_q && all_letters) begin
          kind_d = KIND_CASELESS;
        end else begin
          kind_d = KIND_NONE;
        end
        found_d = (kind_d != KIND_NONE);
      end else begin
        if (count_q != COUNT_MAX) begin
          count_d = count_q + count_t'(1);
        end
        masked_hit_d   = masked_hit_q || masked_now;
        caseless_hit_d = caseless_hit_q || caseless_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      masked_hit_q   <= 1'b0;
      caseless_hit_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      count_q        <= count_d;
      masked_hit_q   <= masked_hit_d;
      caseless_hit_q <= caseless_hit_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    kind_q  <= kind_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.found      = found_q;
  assign out_o.match_kind = kind_q;

`ifndef SYNTHESIS
  // A presented result reports found exactly when some rule matched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.found == (out_o.match_kind != KIND_NONE)))
    else $error("found disagrees with match_kind");

  // A final byte always leaves a result and a cleared stream behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.final_byte) |=> (out_valid_q && count_q == '0 && !masked_hit_q &&
                                     !caseless_hit_q))
    else $error("final byte did not produce a result or clear the stream");

  // Other bytes advance the count by one until it saturates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.final_byte) |=>
      ((count_q == $past(count_q) + count_t'(1)) ||
       ($past(count_q) == COUNT_MAX && count_q == COUNT_MAX)))
    else $error("byte count did not advance");

  // No byte is taken while a result waits and the sink holds it off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while result register is blocked");
`endif

endmodule

>>> rtl/mbss_cell.sv
// One window cell: holds a stream byte and compares the byte entering it with its pattern byte.
module mbss_cell import mbss_pkg::*; (
  input  logic        clk_i,
  input  logic        shift_i,
  input  byte_t       data_i,
  input  idx_t        idx_i,
  input  len_t        len_i,
  input  byte_row_t   pattern_i,
  input  byte_row_t   mask_i,
  output byte_t       data_o,
  output cell_flags_t flags_o
);

  byte_t byte_q;
  len_t  sel;
  byte_t pat;
  byte_t msk;

  // The byte is passed on to the next cell on every accepted item.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= data_i;
    end
  end

  assign data_o = byte_q;

  // Cell k sees the byte that ends up k places back, which meets pattern byte len-1-k.
  assign sel = len_i - len_t'(1) - {1'b0, idx_i};
  assign pat = pattern_i[sel[IDX_W-1:0]];
  assign msk = mask_i[sel[IDX_W-1:0]];

  always_comb begin
    flags_o.active  = ({1'b0, idx_i} < len_i);
    flags_o.mask_ok = ((data_i & msk) == (pat & msk));
    flags_o.case_ok = (fold_case(data_i) == fold_case(pat));
    flags_o.letter  = is_letter(pat);
  end

endmodule
